// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the sleep queue, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define TSQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tsq_pkg.sv =====
// Types and constants of the timed sleep queue.
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

    localparam int ID_W   = 8;
    localparam int TICK_W = 63;
    localparam int ENTRY_W = ID_W + TICK_W;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic REG_IDLE_ID = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SLEEP = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CLOSE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/tsq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds while no read is issued.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/timed_sleep_queue.sv =====
// Top level of the timed sleep queue: sleeper table, scan sequencer and ports.
`timescale 1ns / 1ps
`default_nettype none

// The timed sleep queue keeps up to QUEUE_DEPTH sleeping thread ids, in the
// order they went to sleep, each with its 63-bit wake-up tick, and tracks the
// earliest pending wake tick. A sleep request (tuser 0) appends the thread
// unless it is the idle thread set in the idle_id register (address 0), in
// which case nothing changes, or the table is full, in which case the request
// is dropped and its single result carries queue_full. A tick request
// (tuser 1) carries the current time; every entry due at or before it is
// released in table order with one result each (tuser bit 0 set), the rest are
// compacted in place, and a closing result with tlast carries the new earliest
// wake tick, all ones when the table is empty. Every request ends in exactly
// one tlast result. The table lives in one RAM with a registered read port and
// is walked by a small sequencer around a shared tick comparator, one entry per
// cycle while no due entry waits on the output register, with a second
// comparator that tracks the running minimum of the kept entries. A sleep
// request, each due entry and the closing result of a tick request wait while
// the output register still holds a result that m_axis_tready
// has not taken. The input is not ready while a request is in work,
// but it is ready again while the final result still waits in the output
// register. There is no clearing pass after reset; entries at or above the
// fill count are never read.
module timed_sleep_queue
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata fields from bit 0: thread_id[7:0], tick_value[70:8], zero pad [71].
    input  wire logic [71:0] s_axis_tdata,
    // tuser fields from bit 0: req_type.
    input  wire logic [0:0]  s_axis_tuser,

    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata fields from bit 0: woken_id[7:0], next_wake_tick[70:8], zero pad [71].
    output logic      [71:0] m_axis_tdata,
    // tuser fields from bit 0: woken_valid, queue_full.
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast,

    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Sequencer and request registers.
    t_state              r_state,    n_state;
    logic [ID_W-1:0]     r_idle_id;
    logic [ID_W-1:0]     r_id,       n_id;
    logic [TICK_W-1:0]   r_tick,     n_tick;
    logic [CW-1:0]       r_count,    n_count;
    logic [AW-1:0]       r_rd,       n_rd;
    logic [CW-1:0]       r_wr,       n_wr;
    logic [TICK_W-1:0]   r_next,     n_next;
    logic [TICK_W-1:0]   r_earliest, n_earliest;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic                r_out_woken, n_out_woken;
    logic [ID_W-1:0]     r_out_id,    n_out_id;
    logic [TICK_W-1:0]   r_out_tick,  n_out_tick;
    logic                r_out_full,  n_out_full;
    logic                r_out_last,  n_out_last;

    // Table RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                s_acc;
    logic                out_free;
    logic                cfg_wr;
    logic [TICK_W-1:0]   ent_tick;
    logic [ID_W-1:0]     ent_id;
    logic [TICK_W-1:0]   cmp_b;
    logic                cmp_lt;
    logic                step;

    tsq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign ent_id   = ram_rdata[ID_W-1:0];
    assign ent_tick = ram_rdata[ENTRY_W-1:ID_W];

    // The shared comparator: the request tick against the earliest tick on a
    // sleep, against the stored wake tick during the scan. On the scan, a
    // request tick below the wake tick means the entry stays asleep.
    assign cmp_b  = (r_state == S_SCAN) ? ent_tick : r_earliest;
    assign cmp_lt = (r_tick < cmp_b);

    // Register port. Only one register exists, at word address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_ID);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDLE_ID) begin
            prdata = {{(32 - ID_W){1'b0}}, r_idle_id};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_tick      = r_tick;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_next      = r_next;
        n_earliest  = r_earliest;

        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_woken = r_out_woken;
        n_out_id    = r_out_id;
        n_out_tick  = r_out_tick;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;

        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_tick, r_id};
        ram_re    = 1'b0;
        ram_raddr = '0;
        step      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_id   = s_axis_tdata[ID_W-1:0];
                    n_tick = s_axis_tdata[ENTRY_W-1:ID_W];
                    n_rd   = '0;
                    n_wr   = '0;
                    n_next = TICK_MAX;
                    if (s_axis_tuser[0] == REQ_SLEEP) begin
                        n_state = S_SLEEP;
                    end else if (r_count == '0) begin
                        n_state = S_CLOSE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SLEEP: begin
                if (out_free) begin
                    n_out_full = 1'b0;
                    if (r_id != r_idle_id) begin
                        if (r_count < DEPTH_C) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            if (cmp_lt) begin
                                n_earliest = r_tick;
                            end
                        end else begin
                            n_out_full = 1'b1;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_woken = 1'b0;
                    n_out_id    = '0;
                    n_out_tick  = n_earliest;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_SCAN: begin
                if (cmp_lt) begin
                    // Still asleep: move it down to the compaction slot.
                    step      = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = r_wr[AW-1:0];
                    ram_wdata = ram_rdata;
                    n_wr      = r_wr + CW'(1);
                    if (ent_tick < r_next) begin
                        n_next = ent_tick;
                    end
                end else if (out_free) begin
                    step        = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_woken = 1'b1;
                    n_out_id    = ent_id;
                    n_out_tick  = '0;
                    n_out_full  = 1'b0;
                    n_out_last  = 1'b0;
                end
                if (step) begin
                    if (CW'(r_rd) + CW'(1) == r_count) begin
                        n_state = S_CLOSE;
                    end else begin
                        n_rd      = r_rd + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_rd + AW'(1);
                    end
                end
            end

            S_CLOSE: begin
                if (out_free) begin
                    n_count     = r_wr;
                    n_earliest  = r_next;
                    n_out_valid = 1'b1;
                    n_out_woken = 1'b0;
                    n_out_id    = '0;
                    n_out_tick  = r_next;
                    n_out_full  = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle_id   <= '0;
            r_count     <= '0;
            r_earliest  <= TICK_MAX;
            r_out_valid <= 1'b0;
            r_rd        <= '0;
            r_wr        <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_earliest  <= n_earliest;
            r_out_valid <= n_out_valid;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            if (cfg_wr) begin
                r_idle_id <= pwdata[ID_W-1:0];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_tick      <= n_tick;
        r_next      <= n_next;
        r_out_woken <= n_out_woken;
        r_out_id    <= n_out_id;
        r_out_tick  <= n_out_tick;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_tick, r_out_id};
    assign m_axis_tuser  = {r_out_full, r_out_woken};
    assign m_axis_tlast  = r_out_last;

`include "assert_macros.svh"

    `TSQ_ASSERT(a_count_bound, i_clk, i_rst_n,
        (r_count <= DEPTH_C), "sleeper count above depth")
    `TSQ_ASSERT(a_one_at_a_time, i_clk, i_rst_n,
        (s_acc |=> !s_axis_tready), "request taken while busy")
    `TSQ_ASSERT(a_compact_behind, i_clk, i_rst_n,
        ((r_state == S_SCAN) |-> (r_wr <= CW'(r_rd))), "compaction slot passed scan pointer")
    `TSQ_ASSERT(a_full_means_full, i_clk, i_rst_n,
        ((r_out_valid && r_out_full) |-> (r_count == DEPTH_C)), "queue_full reported with room left")

endmodule

`default_nettype wire

// ===== test/timed_sleep_queue_test.sv =====
// Self-checking testbench for the timed sleep queue: directed and random requests.
`timescale 1ns / 1ps

// Requests go in on the slave stream and results come back on the master
// stream. A predictor keeps its own sleeper table, fill count, earliest wake
// tick and idle thread id. It works out the results of every accepted request
// and appends them to a queue. A checker compares each accepted result with
// the oldest entry of that queue, field by field. Both streams stall in random
// bursts, except in the last phase. The idle id register is written over the
// register port only while no result is outstanding.
module timed_sleep_queue_test;
    import tsq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int HALF_PERIOD = 10;
    // Worst case is about 400 requests of 17 results, each held up by the longest stall burst.
    // The timeout leaves a wide margin over that worst case.
    localparam longint TIMEOUT_NS = 64'd20_000_000;
    localparam int DRAIN_LIMIT = 20000;
    localparam logic [2:0] IDLE_ID_ADDR = {REG_IDLE_ID, 2'b00};

    typedef struct packed {
        logic              woken_valid;
        logic [ID_W-1:0]   woken_id;
        logic [TICK_W-1:0] next_wake;
        logic              queue_full;
        logic              closing;
    } t_wake_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0: thread_id[7:0], tick_value[70:8], zero pad [71].
    logic [71:0] s_axis_tdata = '0;
    // Fields from bit 0: req_type.
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // Fields from bit 0: woken_id[7:0], next_wake_tick[70:8], zero pad [71].
    logic [71:0] m_axis_tdata;
    // Fields from bit 0: woken_valid, queue_full.
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timed_sleep_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Predictor state, kept apart from the block.
    logic [ID_W-1:0]   sleeper_ids [QUEUE_DEPTH];
    logic [TICK_W-1:0] sleeper_ticks [QUEUE_DEPTH];
    int unsigned       sleeper_total = 0;
    logic [TICK_W-1:0] soonest_wake = TICK_MAX;
    logic [ID_W-1:0]   ignored_sleeper = '0;

    t_wake_result expected_wakeups [$];
    int unsigned  mismatch_count = 0;
    bit           steady_flow = 1'b0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    // Applies one accepted request to the predictor state and queues its results.
    task automatic predict_wakeups(input logic req, input logic [ID_W-1:0] id,
                                   input logic [TICK_W-1:0] stamp);
        int unsigned       kept;
        logic [TICK_W-1:0] remaining_min;
        logic              dropped;
        if (req == REQ_SLEEP) begin
            dropped = 1'b0;
            // The idle thread never sleeps; a full table drops the request.
            if (id != ignored_sleeper) begin
                if (sleeper_total >= QUEUE_DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    sleeper_ids[sleeper_total] = id;
                    sleeper_ticks[sleeper_total] = stamp;
                    sleeper_total++;
                    if (stamp < soonest_wake)
                        soonest_wake = stamp;
                end
            end
            expected_wakeups.push_back('{1'b0, '0, soonest_wake, dropped, 1'b1});
        end else begin
            // Release due entries in table order and compact the others in place.
            kept = 0;
            remaining_min = TICK_MAX;
            for (int i = 0; i < sleeper_total; i++) begin
                if (sleeper_ticks[i] <= stamp) begin
                    expected_wakeups.push_back('{1'b1, sleeper_ids[i], '0, 1'b0, 1'b0});
                end else begin
                    sleeper_ids[kept] = sleeper_ids[i];
                    sleeper_ticks[kept] = sleeper_ticks[i];
                    kept++;
                    if (sleeper_ticks[i] < remaining_min)
                        remaining_min = sleeper_ticks[i];
                end
            end
            sleeper_total = kept;
            soonest_wake = remaining_min;
            expected_wakeups.push_back('{1'b0, '0, soonest_wake, 1'b0, 1'b1});
        end
    endtask

    // Offers one request, sometimes after a random gap, and waits for acceptance.
    // The valid stays high afterward so back-to-back requests need no new edge.
    task automatic send_request(input logic req, input logic [ID_W-1:0] id,
                                input logic [TICK_W-1:0] stamp);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, stamp, id};
        s_axis_tuser <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_wakeups(req, id, stamp);
    endtask

    // Stops offering requests and waits until every expected result has come.
    // Then it lets the block settle back into its idle state.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_wakeups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the idle id register with a setup cycle and an access cycle.
    task automatic write_idle_id(input logic [ID_W-1:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= IDLE_ID_ADDR;
        pwdata <= {{(32 - ID_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ignored_sleeper = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] any_tick();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[TICK_W-1:0];
    endfunction

    // Start of the time line for a phase. It leaves room for the phase's
    // increments, so that wake ticks never wrap.
    function automatic logic [TICK_W-1:0] phase_start(input bit near_top);
        if (near_top)
            return TICK_MAX - 63'd16777216 - 63'($urandom_range(0, 1000));
        return any_tick() >> $urandom_range(1, 62);
    endfunction

    // Checks every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_wake_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_wakeups.size() == 0) begin
                flag_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
            end else begin
                want = expected_wakeups.pop_front();
                if (m_axis_tuser[0] !== want.woken_valid)
                    flag_mismatch("woken_valid", 64'(m_axis_tuser[0]),
                                  64'(want.woken_valid));
                if (m_axis_tdata[7:0] !== want.woken_id)
                    flag_mismatch("woken_id", 64'(m_axis_tdata[7:0]), 64'(want.woken_id));
                if (m_axis_tdata[70:8] !== want.next_wake)
                    flag_mismatch("next_wake_tick", 64'(m_axis_tdata[70:8]),
                                  64'(want.next_wake));
                if (m_axis_tuser[1] !== want.queue_full)
                    flag_mismatch("queue_full", 64'(m_axis_tuser[1]), 64'(want.queue_full));
                if (m_axis_tlast !== want.closing)
                    flag_mismatch("tlast", 64'(m_axis_tlast), 64'(want.closing));
            end
        end
    end

    // Result-side back pressure: random stall and run bursts. None in the last phase.
    int unsigned sink_burst = 0;
    bit          sink_stall = 1'b0;
    always @(posedge i_clk) begin
        if (steady_flow) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (sink_burst == 0) begin
                sink_stall = ($urandom_range(0, 2) == 0);
                sink_burst = sink_stall ? $urandom_range(1, 17) : $urandom_range(1, 24);
            end
            sink_burst--;
            m_axis_tready <= !sink_stall;
        end
    end

    // Covers the tick and id extremes, the idle thread at reset, past wake ticks,
    // duplicate ids and a tick request on an empty table.
    task automatic test_basic_wakeups();
        send_request(REQ_TICK, 8'd0, '0);
        send_request(REQ_SLEEP, 8'd0, 63'd3);
        send_request(REQ_SLEEP, 8'd255, TICK_MAX);
        send_request(REQ_SLEEP, 8'd7, '0);
        send_request(REQ_SLEEP, 8'd7, 63'd5);
        send_request(REQ_TICK, 8'd255, 63'd5);
        send_request(REQ_TICK, 8'd0, TICK_MAX);
    endtask

    // Fills the table, overflows it twice, then releases all sixteen entries
    // with a single tick request.
    task automatic test_table_full();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(REQ_SLEEP, 8'($urandom_range(1, 255)), 63'($urandom_range(100, 5000)));
        send_request(REQ_SLEEP, 8'd42, 63'd1);
        send_request(REQ_SLEEP, 8'd43, 63'd2);
        send_request(REQ_TICK, 8'd0, TICK_MAX);
    endtask

    // Moves the idle id to its other extreme. Id 255 is then ignored and id 0 sleeps.
    task automatic test_idle_register();
        write_idle_id(8'd255);
        send_request(REQ_SLEEP, 8'd255, 63'd10);
        send_request(REQ_SLEEP, 8'd0, 63'd10);
        send_request(REQ_TICK, 8'd255, 63'd10);
    endtask

    // Most requests follow a rising time line: sleeps wake shortly after "now",
    // and ticks advance it. A few requests are noise with full-range values.
    // Halfway through, the sender waits until every expected result is in.
    task automatic test_random_traffic(input logic [ID_W-1:0] idle_value, input int count,
                                       input int tick_pct, input bit near_top);
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] wake;
        logic [ID_W-1:0]   id;
        int unsigned       pick;
        write_idle_id(idle_value);
        now = phase_start(near_top);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (n == count / 2)
                drain_results();
            if (pick < 8) begin
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), any_tick());
            end else if (pick < 8 + tick_pct) begin
                now = now + 63'($urandom_range(0, 48));
                send_request(REQ_TICK, 8'($urandom_range(0, 255)), now);
            end else begin
                case ($urandom_range(0, 9))
                    0: id = ignored_sleeper;
                    1, 2, 3: id = 8'($urandom_range(1, 6));
                    default: id = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 7) == 0 && now >= 63'd100)
                    wake = now - 63'($urandom_range(0, 100));
                else
                    wake = now + 63'($urandom_range(0, 64));
                send_request(REQ_SLEEP, id, wake);
            end
        end
    endtask

    // Waits for outstanding results with a limit. Anything still missing
    // counts as a failure.
    task automatic finish_run();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_wakeups.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        while (expected_wakeups.size() != 0) begin
            void'(expected_wakeups.pop_front());
            flag_mismatch("result never arrived", '0, '0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_wakeups();
        test_table_full();
        test_idle_register();
        test_random_traffic(8'd0, 60, 30, 1'b0);
        test_random_traffic(8'd255, 60, 15, 1'b1);
        test_random_traffic(8'($urandom_range(0, 255)), 60, 40, 1'b0);
        test_random_traffic(8'($urandom_range(0, 255)), 60, 25, 1'b1);
        test_random_traffic(8'($urandom_range(0, 255)), 60, 10, 1'b0);
        // The last phase runs without gaps or stalls on either stream.
        drain_results();
        steady_flow = 1'b1;
        test_random_traffic(8'($urandom_range(0, 255)), 50, 25, 1'b0);
        finish_run();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
